>>> design/gedi_pkg.sv
//------------------------------------------------------------------------------
// gedi_pkg: shared types for the GPIO edge interrupt detector
// Request kinds, trigger codes and the command/result words that pass
// between the front end, the queues and the execution back end.
//------------------------------------------------------------------------------
package gedi_pkg;

    localparam int IDX_W   = 5;
    localparam int MODE_W  = 2;
    localparam int LEVEL_W = 32;
    localparam int COUNT_W = 6;

    typedef enum logic [1:0] {
        KIND_POLL   = 2'd0,
        KIND_ARM    = 2'd1,
        KIND_DISARM = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    // trigger modes; any other code means "any change"
    localparam logic [MODE_W-1:0] TRIG_RISE = 2'd0;
    localparam logic [MODE_W-1:0] TRIG_FALL = 2'd1;

    typedef struct packed {
        kind_t              op;
        logic [IDX_W-1:0]   pin;     // already reduced modulo PINS
        logic [MODE_W-1:0]  mode;
        logic [LEVEL_W-1:0] levels;
    } cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] fire_mask;
        logic               polling_active;
        logic [COUNT_W-1:0] armed_count;
    } res_t;

endpackage

>>> design/gpio_edge_interrupt_detector_unit.sv
//------------------------------------------------------------------------------
// gpio_edge_interrupt_detector_unit: per-pin edge interrupt detector
// Queue-style request/result block: poll ticks, arm and disarm requests in,
// one fire mask plus polling status and armed count out per request.
//------------------------------------------------------------------------------
// Usage: push a request while full is low; every request yields exactly one
// result, in order, readable while empty is low and removed with pop. The
// block sustains one request per clock while the reader keeps up. A request
// is classified (kind decode, pin index folded modulo PINS) on the way into a
// QUEUE_DEPTH-entry command queue, the back end executes one command per cycle
// against the pin state registers while the result queue has room, and the
// result lands in a QUEUE_DEPTH-entry result queue. A result reaches the
// result ports once its command has left the command queue and the result
// has been written into the result queue's registers. A slow
// reader fills the result queue, then the command queue, then raises full.
// Poll ticks fire armed pins whose level moved in the armed direction
// (rising, falling, or any change for modes 2 and 3) and record new levels of
// armed pins. Arm stores mode and level, counts a newly armed pin (count wraps
// modulo PINS+1) and turns polling on. Disarm is ignored while polling is off;
// otherwise it clears the pin, decrements a nonzero count and turns polling
// off when the count reaches zero. Pins at 32 and above read low.
//------------------------------------------------------------------------------
module gpio_edge_interrupt_detector_unit #(
    parameter int PINS        = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [4:0]  pin_index,
    input  logic [1:0]  trigger_mode,
    input  logic [31:0] pin_levels,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [31:0] fire_mask,
    output logic        polling_active,
    output logic [5:0]  armed_count
);

    gedi_pkg::cmd_t front_cmd;
    gedi_pkg::cmd_t back_cmd;
    gedi_pkg::res_t back_res;
    gedi_pkg::res_t out_res;
    logic           cmd_empty;
    logic           cmd_pop;
    logic           res_push;
    logic           res_full;

    // classify
    gedi_front #(
        .PINS (PINS)
    ) u_front (
        .kind         (kind),
        .pin_index    (pin_index),
        .trigger_mode (trigger_mode),
        .pin_levels   (pin_levels),
        .cmd          (front_cmd)
    );

    // decouples intake from execution
    gedi_fifo #(
        .WIDTH ($bits(gedi_pkg::cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (back_cmd),
        .empty (cmd_empty)
    );

    // execute
    gedi_back #(
        .PINS (PINS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (!cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (back_res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // results wait here for the reader
    gedi_fifo #(
        .WIDTH ($bits(gedi_pkg::res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

    assign fire_mask      = out_res.fire_mask;
    assign polling_active = out_res.polling_active;
    assign armed_count    = out_res.armed_count;

    // a nonzero count always comes with polling switched on
    a_count_implies_polling: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_push && back_res.armed_count != '0) |-> back_res.polling_active
    ) else $error("armed count nonzero with polling off");

    // the back end only fires pins on a poll tick
    a_fire_only_on_poll: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_push && back_cmd.op != gedi_pkg::KIND_POLL) |-> (back_res.fire_mask == '0)
    ) else $error("fire mask set on arm or disarm");

    // a command leaves its queue exactly when its result enters the result queue
    a_one_result_per_cmd: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (res_push && !res_full && !cmd_empty)
    ) else $error("command consumed without a result");

endmodule

>>> design/gedi_fifo.sv
//------------------------------------------------------------------------------
// gedi_fifo: small register queue
// Count-based full/empty, show-ahead read of the oldest entry.
//------------------------------------------------------------------------------
module gedi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> design/gedi_front.sv
//------------------------------------------------------------------------------
// gedi_front: request classifier
// Decodes the request kind and folds the pin index into range.
//------------------------------------------------------------------------------
module gedi_front #(
    parameter int PINS = 32
) (
    input  logic [1:0]          kind,
    input  logic [4:0]          pin_index,
    input  logic [1:0]          trigger_mode,
    input  logic [31:0]         pin_levels,
    output gedi_pkg::cmd_t      cmd
);

    logic [gedi_pkg::IDX_W-1:0] pin_mod;

    // pin_index modulo PINS as a small constant table
    always_comb
    begin
        pin_mod = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (pin_index == 5'(i))
            begin
                pin_mod = gedi_pkg::IDX_W'(i % PINS);
            end
        end
    end

    always_comb
    begin
        cmd.pin    = pin_mod;
        cmd.mode   = trigger_mode;
        cmd.levels = pin_levels;
        case (kind)
            2'd0:    cmd.op = gedi_pkg::KIND_POLL;
            2'd1:    cmd.op = gedi_pkg::KIND_ARM;
            2'd2:    cmd.op = gedi_pkg::KIND_DISARM;
            default: cmd.op = gedi_pkg::KIND_NOP;
        endcase
    end

endmodule

>>> design/gedi_back.sv
//------------------------------------------------------------------------------
// gedi_back: execution back end
// Holds per-pin arm/trigger/level state and the handler count; runs one command
// per cycle while res_full is low and produces its result word.
//------------------------------------------------------------------------------
module gedi_back #(
    parameter int PINS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  gedi_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    output gedi_pkg::res_t res,
    output logic           res_push,
    input  logic           res_full
);

    localparam int CNT_W = $clog2(PINS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PINS);

    logic [PINS-1:0]       armed_reg, armed_next;
    logic [PINS-1:0][1:0]  trig_reg,  trig_next;
    logic [PINS-1:0]       last_reg,  last_next;
    logic [CNT_W-1:0]      cnt_reg,   cnt_next;
    logic                  poll_reg,  poll_next;

    logic [PINS-1:0]       lvl;
    logic [PINS-1:0]       sel;
    logic [PINS-1:0]       fire;
    logic [31:0]           fire_word;
    logic                  go;
    logic                  was_armed;

    // pins at 32 and above read low and never show up in the mask
    for (genvar n = 0; n < PINS; n++)
    begin : g_pin
        if (n < 32)
        begin : g_lo
            assign lvl[n] = cmd.levels[n];
            assign sel[n] = (cmd.pin == gedi_pkg::IDX_W'(n));
        end
        else
        begin : g_hi
            assign lvl[n] = 1'b0;
            assign sel[n] = 1'b0;
        end
    end

    for (genvar m = 0; m < 32; m++)
    begin : g_mask
        if (m < PINS)
        begin : g_on
            assign fire_word[m] = fire[m];
        end
        else
        begin : g_off
            assign fire_word[m] = 1'b0;
        end
    end

    assign go        = cmd_valid && !res_full;
    assign cmd_pop   = go;
    assign res_push  = go;
    assign was_armed = |(armed_reg & sel);

    always_comb
    begin
        armed_next = armed_reg;
        trig_next  = trig_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        poll_next  = poll_reg;
        fire       = '0;
        if (go)
        begin
            case (cmd.op)
                gedi_pkg::KIND_POLL:
                begin
                    for (int n = 0; n < PINS; n++)
                    begin
                        if (armed_reg[n])
                        begin
                            if (lvl[n] != last_reg[n])
                            begin
                                case (trig_reg[n])
                                    gedi_pkg::TRIG_RISE: fire[n] = !last_reg[n];
                                    gedi_pkg::TRIG_FALL: fire[n] = last_reg[n];
                                    default:             fire[n] = 1'b1;
                                endcase
                            end
                            last_next[n] = lvl[n];
                        end
                    end
                end
                gedi_pkg::KIND_ARM:
                begin
                    for (int n = 0; n < PINS; n++)
                    begin
                        if (sel[n])
                        begin
                            armed_next[n] = 1'b1;
                            trig_next[n]  = cmd.mode;
                            last_next[n]  = lvl[n];
                        end
                    end
                    poll_next = 1'b1;
                    if (!was_armed)
                    begin
                        // count wraps modulo PINS+1
                        cnt_next = (cnt_reg == CNT_MAX) ? '0 : cnt_reg + 1'b1;
                    end
                end
                gedi_pkg::KIND_DISARM:
                begin
                    if (poll_reg)
                    begin
                        for (int n = 0; n < PINS; n++)
                        begin
                            if (sel[n])
                            begin
                                armed_next[n] = 1'b0;
                                last_next[n]  = lvl[n];
                            end
                        end
                        if (cnt_reg != '0)
                        begin
                            cnt_next = cnt_reg - 1'b1;
                            if (cnt_reg == CNT_W'(1))
                            begin
                                poll_next = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res.fire_mask      = fire_word;
        res.polling_active = poll_next;
        res.armed_count    = gedi_pkg::COUNT_W'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= '0;
            trig_reg  <= '0;
            last_reg  <= '0;
            cnt_reg   <= '0;
            poll_reg  <= 1'b0;
        end
        else
        begin
            armed_reg <= armed_next;
            trig_reg  <= trig_next;
            last_reg  <= last_next;
            cnt_reg   <= cnt_next;
            poll_reg  <= poll_next;
        end
    end

endmodule
